// ===== rtl/core/hash_table_linear_probe_core_assert.svh =====
// Assertion macros for the hash table core checker
`ifndef HASH_TABLE_LINEAR_PROBE_CORE_ASSERT_SVH
`define HASH_TABLE_LINEAR_PROBE_CORE_ASSERT_SVH

// check a condition at the same edge
`define HTLP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("htlp assertion failed");

// check a condition at the following edge
`define HTLP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("htlp assertion failed");

`endif

// ===== rtl/core/htlp_pkg.sv =====
// Shared types, constants and functions of the hash table core
package htlp_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int VALUE_BITS_DEF = 32;

	localparam int KEY_W   = 64;
	localparam int LEN_W   = 4;
	localparam int FOUND_W = 32;

	localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
	localparam logic [31:0] HASH_MULT = 32'h01000193;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_LIVE  = 2'd1,
		KIND_GRAVE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic    clr_wr;
		logic    load;
		logic    hash_step;
		logic    mod_step;
		logic    rd;
		logic    ins_wr;
		logic    del_wr;
		logic    advance;
		logic    set_res;
		status_t res;
		logic    take_value;
		logic    fin;
	} cmd_t;

	typedef struct packed {
		logic        clr_last;
		logic        hash_done;
		logic        mod_last;
		logic        full;
		logic [1:0]  op;
		logic [1:0]  kind;
		logic        match;
		logic        probe_last;
		logic        out_free;
	} sts_t;

	function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int i = 0; i < KEY_W / 8; i++) begin
			if (LEN_W'(i) < len) begin
				m[8*i +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/htlp_ctrl.sv =====
// Controller state machine of the hash table core
module htlp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  htlp_pkg::sts_t  sts,
	output htlp_pkg::cmd_t  cmd,
	output logic            idle
);

	htlp_pkg::state_t state_q, state_d;

	logic             mod_finish;
	htlp_pkg::status_t mod_res;
	logic             chk_finish;
	htlp_pkg::status_t chk_res;
	logic             chk_ins;
	logic             chk_del;
	logic             chk_take;
	logic             op_known;
	logic             kind_live;
	logic             kind_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htlp_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		op_known   = (sts.op == htlp_pkg::OP_INSERT) || (sts.op == htlp_pkg::OP_LOOKUP) ||
		             (sts.op == htlp_pkg::OP_DELETE);
		kind_live  = sts.kind == htlp_pkg::KIND_LIVE;
		kind_empty = sts.kind == htlp_pkg::KIND_EMPTY;
		mod_finish = 1'b0;
		mod_res    = htlp_pkg::ST_MISS;
		if (sts.op == htlp_pkg::OP_INSERT && sts.full) begin
			mod_finish = 1'b1;
			mod_res    = htlp_pkg::ST_FULL;
		end else if (!op_known) begin
			mod_finish = 1'b1;
		end
		chk_finish = 1'b0;
		chk_res    = htlp_pkg::ST_MISS;
		chk_ins    = 1'b0;
		chk_del    = 1'b0;
		chk_take   = 1'b0;
		if (sts.op == htlp_pkg::OP_INSERT) begin
			if (!kind_live) begin
				chk_finish = 1'b1;
				chk_res    = htlp_pkg::ST_OK;
				chk_ins    = 1'b1;
			end else if (sts.probe_last) begin
				chk_finish = 1'b1;
				chk_res    = htlp_pkg::ST_FULL;
			end
		end else begin
			if (kind_empty) begin
				chk_finish = 1'b1;
			end else if (kind_live && sts.match) begin
				chk_finish = 1'b1;
				chk_res    = htlp_pkg::ST_OK;
				chk_take   = sts.op == htlp_pkg::OP_LOOKUP;
				chk_del    = sts.op == htlp_pkg::OP_DELETE;
			end else if (sts.probe_last) begin
				chk_finish = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htlp_pkg::S_CLEAR: begin
				if (sts.clr_last) state_d = htlp_pkg::S_IDLE;
			end
			htlp_pkg::S_IDLE: begin
				if (in_valid) state_d = htlp_pkg::S_HASH;
			end
			htlp_pkg::S_HASH: begin
				if (sts.hash_done) state_d = htlp_pkg::S_MOD;
			end
			htlp_pkg::S_MOD: begin
				if (sts.mod_last) begin
					state_d = mod_finish ? htlp_pkg::S_FINISH : htlp_pkg::S_PROBE_RD;
				end
			end
			htlp_pkg::S_PROBE_RD: state_d = htlp_pkg::S_PROBE_CHK;
			htlp_pkg::S_PROBE_CHK: begin
				state_d = chk_finish ? htlp_pkg::S_FINISH : htlp_pkg::S_PROBE_RD;
			end
			htlp_pkg::S_FINISH: begin
				if (sts.out_free) state_d = htlp_pkg::S_IDLE;
			end
			default: state_d = htlp_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = state_q == htlp_pkg::S_IDLE;
		unique case (state_q)
			htlp_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
			htlp_pkg::S_IDLE: cmd.load = in_valid;
			htlp_pkg::S_HASH: cmd.hash_step = !sts.hash_done;
			htlp_pkg::S_MOD: begin
				cmd.mod_step = 1'b1;
				cmd.set_res  = sts.mod_last && mod_finish;
				cmd.res      = mod_res;
			end
			htlp_pkg::S_PROBE_RD: cmd.rd = 1'b1;
			htlp_pkg::S_PROBE_CHK: begin
				cmd.set_res    = chk_finish;
				cmd.res        = chk_res;
				cmd.take_value = chk_take;
				cmd.ins_wr     = chk_ins;
				cmd.del_wr     = chk_del;
				cmd.advance    = !chk_finish;
			end
			htlp_pkg::S_FINISH: cmd.fin = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/htlp_dp.sv =====
// Datapath of the hash table core: hash, slot index, slot memory, counters, result
module htlp_dp #(
	parameter int CAPACITY   = htlp_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES  = htlp_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = htlp_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  htlp_pkg::cmd_t                 cmd,
	output htlp_pkg::sts_t                 sts,
	input  logic [1:0]                     operation,
	input  logic [htlp_pkg::KEY_W-1:0]     key,
	input  logic [htlp_pkg::LEN_W-1:0]     key_length,
	input  logic [VALUE_BITS-1:0]          value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [htlp_pkg::FOUND_W-1:0]   found_value
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = IW + 1;
	localparam int MW   = IW + 1;
	localparam int KW   = 8 * KEY_BYTES;
	localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CAPACITY));

	logic [1:0]                   kind_mem [CAPACITY];
	logic [KW-1:0]                key_mem  [CAPACITY];
	logic [htlp_pkg::LEN_W-1:0]   len_mem  [CAPACITY];
	logic [VALUE_BITS-1:0]        val_mem  [CAPACITY];

	logic [1:0]                   op_q;
	logic [KW-1:0]                key_q;
	logic [htlp_pkg::LEN_W-1:0]   len_q;
	logic [VALUE_BITS-1:0]        val_q;
	logic [31:0]                  h_q;
	logic [KW-1:0]                hk_q;
	logic [htlp_pkg::LEN_W-1:0]   hcnt_q;
	logic [1:0]                   mod_cnt_q;
	logic [31:0]                  qhat_q;
	logic [MW-1:0]                rem_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                pcnt_q;
	logic [CW-1:0]                live_q;
	logic [CW-1:0]                grave_q;
	logic [IW-1:0]                clr_q;
	logic [1:0]                   rd_kind_q;
	logic [KW-1:0]                rd_key_q;
	logic [htlp_pkg::LEN_W-1:0]   rd_len_q;
	logic [VALUE_BITS-1:0]        rd_val_q;
	htlp_pkg::status_t            res_status_q;
	logic [htlp_pkg::FOUND_W-1:0] res_found_q;
	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [htlp_pkg::FOUND_W-1:0] found_q;

	logic [htlp_pkg::LEN_W-1:0]   len_sat;
	logic [htlp_pkg::KEY_W-1:0]   key_m;
	logic [31:0]                  h_next;
	logic [63:0]                  mul_full;
	logic [31:0]                  sub_full;
	logic [MW-1:0]                rem_fix;
	logic [CW:0]                  fill_sum;
	logic [CW+1:0]                fill_dbl;
	logic [IW-1:0]                wr_addr;
	logic [1:0]                   wr_kind;
	logic [htlp_pkg::FOUND_W-1:0] rd_val32;
	logic                         out_free;

	generate
		if (VALUE_BITS >= htlp_pkg::FOUND_W) begin : g_val_wide
			assign rd_val32 = rd_val_q[htlp_pkg::FOUND_W-1:0];
		end else begin : g_val_narrow
			assign rd_val32 = {{(htlp_pkg::FOUND_W-VALUE_BITS){1'b0}}, rd_val_q};
		end
	endgenerate

	always_comb begin
		len_sat   = (key_length > htlp_pkg::LEN_W'(KEY_BYTES)) ?
		            htlp_pkg::LEN_W'(KEY_BYTES) : key_length;
		key_m     = key & htlp_pkg::key_mask(len_sat);
		h_next    = (h_q ^ {24'd0, hk_q[7:0]}) * htlp_pkg::HASH_MULT;
		mul_full  = {32'd0, h_q} * {32'd0, RECIP};
		sub_full  = h_q - qhat_q * 32'(CAPACITY);
		rem_fix   = (rem_q >= MW'(CAPACITY)) ? rem_q - MW'(CAPACITY) : rem_q;
		fill_sum  = (CW+1)'(live_q) + (CW+1)'(grave_q) + (CW+1)'(1);
		fill_dbl  = {fill_sum, 1'b0};
		wr_addr   = cmd.clr_wr ? clr_q : idx_q;
		wr_kind   = cmd.clr_wr ? htlp_pkg::KIND_EMPTY :
		            cmd.ins_wr ? htlp_pkg::KIND_LIVE : htlp_pkg::KIND_GRAVE;
		out_free  = !out_valid_q || !out_stall;
	end

	always_comb begin
		sts.clr_last   = clr_q == IW'(CAPACITY - 1);
		sts.hash_done  = hcnt_q == len_q;
		sts.mod_last   = POW2 || (mod_cnt_q == 2'd2);
		sts.full       = fill_dbl >= (CW+2)'(CAPACITY);
		sts.op         = op_q;
		sts.kind       = rd_kind_q;
		sts.match      = (rd_len_q == len_q) && (rd_key_q == key_q);
		sts.probe_last = pcnt_q == IW'(CAPACITY - 1);
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr || cmd.ins_wr || cmd.del_wr) begin
			kind_mem[wr_addr] <= wr_kind;
		end
		if (cmd.ins_wr) begin
			key_mem[idx_q] <= key_q;
			len_mem[idx_q] <= len_q;
			val_mem[idx_q] <= val_q;
		end
		if (cmd.rd) begin
			rd_kind_q <= kind_mem[idx_q];
			rd_key_q  <= key_mem[idx_q];
			rd_len_q  <= len_mem[idx_q];
			rd_val_q  <= val_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= operation;
			key_q     <= key_m[KW-1:0];
			hk_q      <= key_m[KW-1:0];
			len_q     <= len_sat;
			val_q     <= value;
			h_q       <= htlp_pkg::FNV_BASIS;
			hcnt_q    <= '0;
			mod_cnt_q <= '0;
			rem_q     <= '0;
		end
		if (cmd.hash_step) begin
			h_q    <= h_next;
			hk_q   <= hk_q >> 8;
			hcnt_q <= hcnt_q + 1'b1;
		end
		if (cmd.mod_step) begin
			pcnt_q <= '0;
			if (POW2) begin
				idx_q <= h_q[IW-1:0];
			end else begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
				if (mod_cnt_q == 2'd0) qhat_q <= mul_full[63:32];
				if (mod_cnt_q == 2'd1) rem_q <= sub_full[MW-1:0];
				if (mod_cnt_q == 2'd2) idx_q <= rem_fix[IW-1:0];
			end
		end
		if (cmd.advance) begin
			idx_q  <= (idx_q == IW'(CAPACITY - 1)) ? '0 : idx_q + 1'b1;
			pcnt_q <= pcnt_q + 1'b1;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res;
			res_found_q  <= cmd.take_value ? rd_val32 : '0;
		end
		if (cmd.fin) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			live_q      <= '0;
			grave_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.ins_wr) begin
				live_q <= live_q + 1'b1;
				if (rd_kind_q == htlp_pkg::KIND_GRAVE && grave_q != '0) begin
					grave_q <= grave_q - 1'b1;
				end
			end
			if (cmd.del_wr) begin
				if (live_q != '0) live_q <= live_q - 1'b1;
				grave_q <= grave_q + 1'b1;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;

endmodule

// ===== rtl/core/hash_table_linear_probe_core.sv =====
// Top level of the open-addressing hash table core
// One request is handled at a time. After reset a clearing pass marks every slot empty
// before the first transfer is taken. A request is then captured, hashed with FNV-1a one
// key byte at a time (one 32-bit multiply per byte) followed by a closing step, and given
// its slot index from the low hash bits when CAPACITY is a power of two or by a reciprocal
// multiply, subtract and correction otherwise. Each probed slot is read through the
// registered read port of the slot memory and then checked; the result is handed to the
// output register once that register is free. A refused insert or an unused operation
// probes no slot. The output register lets the next request enter while a result still
// waits to be taken.
module hash_table_linear_probe_core #(
	parameter int CAPACITY   = htlp_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES  = htlp_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = htlp_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [htlp_pkg::KEY_W-1:0]     key,
	input  logic [htlp_pkg::LEN_W-1:0]     key_length,
	input  logic [VALUE_BITS-1:0]          value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [htlp_pkg::FOUND_W-1:0]   found_value
);

	htlp_pkg::cmd_t cmd;
	htlp_pkg::sts_t sts;
	logic           idle;

	htlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	htlp_dp #(
		.CAPACITY   (CAPACITY),
		.KEY_BYTES  (KEY_BYTES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.key         (key),
		.key_length  (key_length),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_value (found_value)
	);

	assign in_stall = !idle;

endmodule

// ===== rtl/core/htlp_chk.sv =====
// Port checker of the hash table core and its bind
`include "hash_table_linear_probe_core_assert.svh"

module htlp_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   status,
	input logic [htlp_pkg::FOUND_W-1:0] found_value
);

	`HTLP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`HTLP_ASSERT_NOW(a_miss_zero, out_valid && status != htlp_pkg::ST_OK, found_value == '0)
	`HTLP_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

endmodule

bind hash_table_linear_probe_core htlp_chk u_htlp_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.found_value (found_value)
);

// ===== tb/hash_table_linear_probe_core_tb.sv =====
// Self-checking testbench for the linear-probing hash table core
module hash_table_linear_probe_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = 256;
	localparam int MAX_BYTES = 8;
	localparam int N_RANDOM  = 900;
	localparam int POOL_N    = 48;
	localparam int LIMIT     = 3000000;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] k;
		logic [3:0]  len;
		logic [31:0] val;
	} request_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] fv;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [63:0] key;
	logic [3:0]  key_length;
	logic [31:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] found_value;

	request_t pending_q[$];
	reply_t   reply_q[$];
	int       n_total;
	int       n_taken;
	int       n_errors;
	int       cycles;
	int       phase;

	htlp_pkg::kind_t tbl_kind[SLOTS];
	logic [63:0]     tbl_key[SLOTS];
	logic [3:0]      tbl_len[SLOTS];
	logic [31:0]     tbl_val[SLOTS];
	int              n_live;
	int              n_grave;

	hash_table_linear_probe_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .key(key), .key_length(key_length), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found_value(found_value)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] fnv1a(input logic [63:0] k, input int len);
		logic [31:0] h;
		h = htlp_pkg::FNV_BASIS;
		for (int i = 0; i < len; i++) begin
			h = (h ^ {24'd0, k[8*i +: 8]}) * htlp_pkg::HASH_MULT;
		end
		return h;
	endfunction

	function automatic int probe_match(input logic [63:0] k, input int len, input int home);
		int idx;
		idx = home;
		for (int n = 0; n < SLOTS; n++) begin
			if (tbl_kind[idx] == htlp_pkg::KIND_EMPTY)
				return -1;
			if (tbl_kind[idx] == htlp_pkg::KIND_LIVE && tbl_len[idx] == len &&
			    tbl_key[idx] == k)
				return idx;
			idx = (idx + 1) % SLOTS;
		end
		return -1;
	endfunction

	function automatic reply_t table_reply(input request_t r);
		reply_t      res;
		int          len;
		int          home;
		int          idx;
		int          hit;
		logic [63:0] k;
		len = (r.len > MAX_BYTES) ? MAX_BYTES : int'(r.len);
		k = '0;
		for (int i = 0; i < len; i++)
			k[8*i +: 8] = r.k[8*i +: 8];
		home = int'(fnv1a(k, len) % SLOTS);
		res.st = htlp_pkg::ST_MISS;
		res.fv = '0;
		if (r.op == htlp_pkg::OP_INSERT) begin
			if (2 * (n_live + n_grave + 1) >= SLOTS) begin
				res.st = htlp_pkg::ST_FULL;
			end else begin
				idx = home;
				for (int n = 0; n < SLOTS; n++) begin
					if (tbl_kind[idx] != htlp_pkg::KIND_LIVE)
						break;
					idx = (idx + 1) % SLOTS;
				end
				if (tbl_kind[idx] == htlp_pkg::KIND_LIVE) begin
					res.st = htlp_pkg::ST_FULL;
				end else begin
					if (tbl_kind[idx] == htlp_pkg::KIND_GRAVE && n_grave > 0)
						n_grave--;
					n_live++;
					tbl_kind[idx] = htlp_pkg::KIND_LIVE;
					tbl_key[idx] = k;
					tbl_len[idx] = 4'(len);
					tbl_val[idx] = r.val;
					res.st = htlp_pkg::ST_OK;
				end
			end
		end else if (r.op == htlp_pkg::OP_LOOKUP) begin
			hit = probe_match(k, len, home);
			if (hit >= 0) begin
				res.st = htlp_pkg::ST_OK;
				res.fv = tbl_val[hit];
			end
		end else if (r.op == htlp_pkg::OP_DELETE) begin
			hit = probe_match(k, len, home);
			if (hit >= 0) begin
				tbl_kind[hit] = htlp_pkg::KIND_GRAVE;
				if (n_live > 0)
					n_live--;
				n_grave++;
				res.st = htlp_pkg::ST_OK;
			end
		end
		return res;
	endfunction

	function automatic bit roll(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	task automatic add_req(input logic [1:0] op, input logic [63:0] k, input logic [3:0] len,
			input logic [31:0] val);
		request_t r;
		r.op = op;
		r.k = k;
		r.len = len;
		r.val = val;
		pending_q.push_back(r);
		n_total++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				reply_q.push_back(table_reply({operation, key, key_length, value}));
				n_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_q.size() > 0 && !((phase == 1 && roll(58)) || (phase == 3 && roll(7)))) begin
					request_t r;
					r = pending_q.pop_front();
					operation <= r.op;
					key <= r.k;
					key_length <= r.len;
					value <= r.val;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (reply_q.size() == 0) begin
					$display("%0t unexpected transfer status %0d found_value %h", $time, status,
						found_value);
					n_errors++;
				end else begin
					reply_t e;
					e = reply_q.pop_front();
					if (status !== e.st) begin
						$display("%0t status expected %0d actual %0d", $time, e.st, status);
						n_errors++;
					end
					if (found_value !== e.fv) begin
						$display("%0t found_value expected %h actual %h", $time, e.fv, found_value);
						n_errors++;
					end
				end
			end
			out_stall <= (phase == 2 && roll(58)) || (phase == 3 && roll(7));
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [63:0] pool_key[POOL_N];
		logic [3:0]  pool_len[POOL_N];
		int          p;
		int          sel;
		for (int i = 0; i < SLOTS; i++)
			tbl_kind[i] = htlp_pkg::KIND_EMPTY;
		n_live = 0;
		n_grave = 0;
		n_total = 0;
		n_taken = 0;
		n_errors = 0;
		cycles = 0;
		phase = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = htlp_pkg::OP_INSERT;
		key = '0;
		key_length = '0;
		value = '0;
		out_stall = 1'b0;

		add_req(htlp_pkg::OP_LOOKUP, '1, 4'd8, '0);
		add_req(htlp_pkg::OP_INSERT, '1, 4'd8, '1);
		add_req(htlp_pkg::OP_LOOKUP, '1, 4'd8, '0);
		add_req(htlp_pkg::OP_LOOKUP, '1, 4'd15, '0);
		add_req(htlp_pkg::OP_INSERT, 64'h0, 4'd0, 32'h0);
		add_req(htlp_pkg::OP_LOOKUP, 64'hdead, 4'd0, '1);
		add_req(htlp_pkg::OP_INSERT, 64'hffff_ffff_ff12_3456, 4'd3, 32'h1234_5678);
		add_req(htlp_pkg::OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd3, '0);
		add_req(htlp_pkg::OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd4, '0);
		add_req(htlp_pkg::OP_INSERT, 64'h0000_0000_0012_3456, 4'd3, 32'hcafe_f00d);
		add_req(htlp_pkg::OP_DELETE, 64'h0000_0000_0012_3456, 4'd3, '0);
		add_req(htlp_pkg::OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd3, '0);
		add_req(htlp_pkg::OP_DELETE, 64'h0000_0000_0012_3456, 4'd3, '0);
		add_req(htlp_pkg::OP_DELETE, 64'h0000_0000_0012_3456, 4'd3, '0);
		add_req(htlp_pkg::OP_INSERT, 64'h0000_0000_0012_3456, 4'd3, 32'h5555_aaaa);
		add_req(htlp_pkg::OP_LOOKUP, 64'h0000_0000_0012_3456, 4'd3, '0);
		add_req(2'd3, '1, 4'd8, '1);
		add_req(htlp_pkg::OP_DELETE, 64'h0, 4'd0, '0);
		add_req(htlp_pkg::OP_LOOKUP, 64'h0, 4'd0, '0);
		add_req(htlp_pkg::OP_DELETE, 64'h1, 4'd12, '0);

		for (int i = 0; i < POOL_N; i++) begin
			pool_key[i] = {$urandom, $urandom};
			pool_len[i] = 4'($urandom_range(15, 0));
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			p = $urandom_range(99, 0);
			sel = $urandom_range(POOL_N - 1, 0);
			if (p < 6)
				add_req(2'($urandom_range(3, 0)), {$urandom, $urandom},
					4'($urandom_range(15, 0)), $urandom);
			else if (p < 40)
				add_req(htlp_pkg::OP_INSERT, pool_key[sel], pool_len[sel], $urandom);
			else if (p < 72)
				add_req(htlp_pkg::OP_LOOKUP, pool_key[sel], pool_len[sel], $urandom);
			else if (p < 96)
				add_req(htlp_pkg::OP_DELETE, pool_key[sel], pool_len[sel], $urandom);
			else
				add_req(2'd3, pool_key[sel], pool_len[sel], $urandom);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (n_taken < n_total || reply_q.size() > 0) begin
			@(posedge clk);
			phase = (n_taken * 4) / n_total;
			if (phase > 3)
				phase = 3;
		end
		repeat (600) @(posedge clk);
		if (n_errors == 0 && reply_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== hash_table_linear_probe_core.f =====
+incdir+rtl/core
rtl/core/htlp_pkg.sv
rtl/core/htlp_ctrl.sv
rtl/core/htlp_dp.sv
rtl/core/hash_table_linear_probe_core.sv
rtl/core/htlp_chk.sv
tb/hash_table_linear_probe_core_tb.sv
